[design/ccol_pkg.sv]
// ----------------------------------------------------------------------------
// ccol_pkg
// Shared types, widths and codes for the circle collision test pipeline.
// ----------------------------------------------------------------------------
package ccol_pkg;

  localparam int COORD_BITS = 16;
  localparam int DELTA_W    = COORD_BITS + 1;
  localparam int RAD_W      = 15;
  localparam int IDX_W      = 2;
  localparam int PROD_W     = 2 * DELTA_W;
  localparam int A_W        = PROD_W;
  localparam int HB_W       = PROD_W + 1;
  localparam int N_W        = HB_W + 1;
  localparam int Q_W        = 64;
  localparam int ROOT_W     = Q_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int QUOT_W     = 20;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DREM_W     = A_W + 1;
  localparam int MAG_W      = COORD_BITS;
  localparam int MP_W       = MAG_W + N_W;
  localparam int DVD_W      = MP_W + 3;
  localparam int PT_W       = QUOT_W + 2;
  localparam int DIV_LANES  = 4;

  localparam int LANE_X1 = 0;
  localparam int LANE_Y1 = 1;
  localparam int LANE_X2 = 2;
  localparam int LANE_Y2 = 3;

  typedef enum logic [1:0] {
    FUNC_RECT = 2'd0,
    FUNC_SEG  = 2'd1,
    FUNC_CIRC = 2'd2
  } func_t;

  localparam logic [IDX_W-1:0] REG_CENTER_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_W-1:0]    delta_t;
  typedef logic        [RAD_W-1:0]      radius_t;

  typedef struct packed {
    logic [1:0] func;
    coord_t     rect_x;
    coord_t     rect_y;
    radius_t    rect_w;
    radius_t    rect_h;
    coord_t     seg_start_x;
    coord_t     seg_start_y;
    coord_t     seg_end_x;
    coord_t     seg_end_y;
    coord_t     other_x;
    coord_t     other_y;
    radius_t    other_radius;
  } req_t;

  typedef struct packed {
    coord_t  center_x;
    coord_t  center_y;
    radius_t circle_radius;
  } cfg_t;

  // per-item data riding alongside the root and divide cells
  typedef struct packed {
    logic                   seg_ok;
    logic                   hit_rc;
    coord_t                 pt_x;
    coord_t                 pt_y;
    delta_t                 dx;
    delta_t                 dy;
    coord_t                 sx;
    coord_t                 sy;
    coord_t                 ex;
    coord_t                 ey;
    logic signed [HB_W-1:0] hb;
    logic [A_W-1:0]         a;
  } carry_t;

  typedef struct packed {
    logic [Q_W-1:0]    x;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QUOT_W-1:0] bits;
    logic              neg;
  } div_lane_t;

  typedef struct packed {
    logic [DREM_W-1:0]               d;
    div_lane_t [DIV_LANES-1:0]       lane;
  } div_t;

  function automatic logic in_box(input logic signed [PT_W-1:0] p,
                                  input coord_t e0, input coord_t e1);
    logic signed [PT_W-1:0] lo;
    logic signed [PT_W-1:0] hi;
    lo = (e0 < e1) ? PT_W'(e0) : PT_W'(e1);
    hi = (e0 < e1) ? PT_W'(e1) : PT_W'(e0);
    return (lo <= p) && (p <= hi);
  endfunction

endpackage

[design/ccol_if.sv]
// ----------------------------------------------------------------------------
// ccol interfaces
// Valid/ready channels for configuration, request items and result items.
// ----------------------------------------------------------------------------
interface ccol_cfg_if;
  import ccol_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [IDX_W-1:0]      index;
  logic [COORD_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ccol_req_if;
  import ccol_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  coord_t     rect_x;
  coord_t     rect_y;
  radius_t    rect_w;
  radius_t    rect_h;
  coord_t     seg_start_x;
  coord_t     seg_start_y;
  coord_t     seg_end_x;
  coord_t     seg_end_y;
  coord_t     other_x;
  coord_t     other_y;
  radius_t    other_radius;
  modport source (output valid, func, rect_x, rect_y, rect_w, rect_h, seg_start_x,
                  seg_start_y, seg_end_x, seg_end_y, other_x, other_y, other_radius,
                  input ready);
  modport sink   (input valid, func, rect_x, rect_y, rect_w, rect_h, seg_start_x,
                  seg_start_y, seg_end_x, seg_end_y, other_x, other_y, other_radius,
                  output ready);
endinterface

interface ccol_rsp_if;
  import ccol_pkg::*;
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink   (input valid, hit, point_x, point_y, output ready);
endinterface

[design/ccol_front.sv]
// ----------------------------------------------------------------------------
// ccol_front
// Five-stage front end: clamps, deltas, squares, line quadratic terms and the
// root radicand for the segment test.
// ----------------------------------------------------------------------------
module ccol_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  ccol_pkg::req_t  req_item,
  input  ccol_pkg::cfg_t  cfg_regs,
  output logic            out_valid,
  output ccol_pkg::sqrt_t out_sqrt,
  output ccol_pkg::carry_t out_carry
);
  import ccol_pkg::*;

  localparam int A_LO = A_W / 2;
  localparam int R2_W = 2 * RAD_W;

  // stage 0
  delta_t                rect_r, rect_b;
  coord_t                qx0, qy0;
  delta_t                ux0, uy0, dx0, dy0, fx0, fy0;
  logic [COORD_BITS-1:0] t0;

  always_comb begin
    rect_r = DELTA_W'(req_item.rect_x) + $signed({2'b00, req_item.rect_w});
    rect_b = DELTA_W'(req_item.rect_y) + $signed({2'b00, req_item.rect_h});
    if (cfg_regs.center_x < req_item.rect_x) begin
      qx0 = req_item.rect_x;
    end else if (DELTA_W'(cfg_regs.center_x) > rect_r) begin
      qx0 = rect_r[COORD_BITS-1:0];
    end else begin
      qx0 = cfg_regs.center_x;
    end
    if (cfg_regs.center_y < req_item.rect_y) begin
      qy0 = req_item.rect_y;
    end else if (DELTA_W'(cfg_regs.center_y) > rect_b) begin
      qy0 = rect_b[COORD_BITS-1:0];
    end else begin
      qy0 = cfg_regs.center_y;
    end
    if (req_item.func == FUNC_CIRC) begin
      ux0 = DELTA_W'(cfg_regs.center_x) - DELTA_W'(req_item.other_x);
      uy0 = DELTA_W'(cfg_regs.center_y) - DELTA_W'(req_item.other_y);
      t0  = COORD_BITS'(cfg_regs.circle_radius) + COORD_BITS'(req_item.other_radius);
    end else begin
      ux0 = DELTA_W'(cfg_regs.center_x) - DELTA_W'(qx0);
      uy0 = DELTA_W'(cfg_regs.center_y) - DELTA_W'(qy0);
      t0  = COORD_BITS'(cfg_regs.circle_radius);
    end
    dx0 = DELTA_W'(req_item.seg_end_x) - DELTA_W'(req_item.seg_start_x);
    dy0 = DELTA_W'(req_item.seg_end_y) - DELTA_W'(req_item.seg_start_y);
    fx0 = DELTA_W'(req_item.seg_start_x) - DELTA_W'(cfg_regs.center_x);
    fy0 = DELTA_W'(req_item.seg_start_y) - DELTA_W'(cfg_regs.center_y);
  end

  // stage 1
  logic                  v1;
  logic [1:0]            func1;
  delta_t                ux1, uy1, dx1, dy1, fx1, fy1;
  coord_t                qx1, qy1, sx1, sy1, ex1, ey1;
  logic [COORD_BITS-1:0] t1;
  radius_t               r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func1 <= req_item.func;
      ux1   <= ux0;
      uy1   <= uy0;
      dx1   <= dx0;
      dy1   <= dy0;
      fx1   <= fx0;
      fy1   <= fy0;
      qx1   <= qx0;
      qy1   <= qy0;
      sx1   <= req_item.seg_start_x;
      sy1   <= req_item.seg_start_y;
      ex1   <= req_item.seg_end_x;
      ey1   <= req_item.seg_end_y;
      t1    <= t0;
      r1    <= cfg_regs.circle_radius;
    end
  end

  // stage 2: products
  logic                     v2;
  logic [1:0]               func2;
  logic signed [PROD_W-1:0] sq_ux, sq_uy;
  logic signed [PROD_W-1:0] p_ddx, p_ddy, p_hx, p_hy, p_cxa, p_cya;
  logic [HB_W-1:0]          uu2;
  logic [2*COORD_BITS-1:0]  t2;
  logic [R2_W-1:0]          r2_2;
  delta_t                   dx2, dy2;
  coord_t                   qx2, qy2, sx2, sy2, ex2, ey2;

  assign sq_ux = ux1 * ux1;
  assign sq_uy = uy1 * uy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      func2 <= func1;
      p_ddx <= dx1 * dx1;
      p_ddy <= dy1 * dy1;
      p_hx  <= fx1 * dx1;
      p_hy  <= fy1 * dy1;
      p_cxa <= fx1 * dy1;
      p_cya <= fy1 * dx1;
      uu2   <= HB_W'($unsigned(sq_ux)) + HB_W'($unsigned(sq_uy));
      t2    <= t1 * t1;
      r2_2  <= r1 * r1;
      dx2   <= dx1;
      dy2   <= dy1;
      qx2   <= qx1;
      qy2   <= qy1;
      sx2   <= sx1;
      sy2   <= sy1;
      ex2   <= ex1;
      ey2   <= ey1;
    end
  end

  // stage 3: sums, hit of the rectangle and circle tests
  logic                   v3, seg3;
  logic                   hit_rc2;
  logic signed [HB_W-1:0] cr2;
  logic [HB_W-1:0]        acr3;
  logic [R2_W-1:0]        r2_3;
  carry_t                 c3;

  assign hit_rc2 = ((func2 == FUNC_RECT) || (func2 == FUNC_CIRC)) && (uu2 <= HB_W'(t2));
  assign cr2     = HB_W'(p_cxa) - HB_W'(p_cya);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg3      <= (func2 == FUNC_SEG);
      acr3      <= cr2[HB_W-1] ? $unsigned(-cr2) : $unsigned(cr2);
      r2_3      <= r2_2;
      c3.seg_ok <= 1'b0;
      c3.hit_rc <= hit_rc2;
      c3.pt_x   <= (hit_rc2 && (func2 == FUNC_RECT)) ? qx2 : '0;
      c3.pt_y   <= (hit_rc2 && (func2 == FUNC_RECT)) ? qy2 : '0;
      c3.dx     <= dx2;
      c3.dy     <= dy2;
      c3.sx     <= sx2;
      c3.sy     <= sy2;
      c3.ex     <= ex2;
      c3.ey     <= ey2;
      c3.hb     <= HB_W'(p_hx) + HB_W'(p_hy);
      c3.a      <= A_W'($unsigned(p_ddx)) + A_W'($unsigned(p_ddy));
    end
  end

  // stage 4: a*r^2 in two halves, cross term squared
  logic                   v4, seg4, small4, nz4;
  logic [A_LO+R2_W-1:0]   plo4;
  logic [A_W-A_LO+R2_W-1:0] phi4;
  logic [Q_W-1:0]         acr2_4;
  carry_t                 c4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg4   <= seg3;
      small4 <= (acr3[HB_W-1:ROOT_W] == '0);
      nz4    <= (c3.a != '0);
      plo4   <= c3.a[A_LO-1:0] * r2_3;
      phi4   <= c3.a[A_W-1:A_LO] * r2_3;
      acr2_4 <= acr3[ROOT_W-1:0] * acr3[ROOT_W-1:0];
      c4     <= c3;
    end
  end

  // stage 5: radicand
  logic [Q_W-1:0] ar2;
  carry_t         c5;

  assign ar2 = Q_W'(plo4) + Q_W'({phi4, {A_LO{1'b0}}});

  always_comb begin
    c5        = c4;
    c5.seg_ok = seg4 && nz4 && small4 && (acr2_4 <= ar2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sqrt.x    <= ar2 - acr2_4;
      out_sqrt.rem  <= '0;
      out_sqrt.root <= '0;
      out_carry     <= c5;
    end
  end

endmodule

[design/ccol_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// ccol_sqrt_cell
// One digit of the floor square root: two radicand bits in, one root bit out.
// ----------------------------------------------------------------------------
module ccol_sqrt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ccol_pkg::sqrt_t  in_sqrt,
  input  ccol_pkg::carry_t in_carry,
  output logic             out_valid,
  output ccol_pkg::sqrt_t  out_sqrt,
  output ccol_pkg::carry_t out_carry
);
  import ccol_pkg::*;

  logic [SREM_W:0] rem_sh;
  logic [SREM_W:0] trial;
  logic            ge;

  assign rem_sh = {in_sqrt.rem[SREM_W-2:0], in_sqrt.x[Q_W-1 -: 2]};
  assign trial  = {1'b0, in_sqrt.root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_sqrt.x    <= {in_sqrt.x[Q_W-3:0], 2'b00};
      out_sqrt.rem  <= ge ? SREM_W'(rem_sh - trial) : rem_sh[SREM_W-1:0];
      out_sqrt.root <= {in_sqrt.root[ROOT_W-2:0], ge};
      out_carry     <= in_carry;
    end
  end

endmodule

[design/ccol_mid.sv]
// ----------------------------------------------------------------------------
// ccol_mid
// Two stages between root and divider: root candidates, then the scaled
// numerators and divider set-up for the four rounded quotients.
// ----------------------------------------------------------------------------
module ccol_mid (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ccol_pkg::ROOT_W-1:0] in_root,
  input  ccol_pkg::carry_t in_carry,
  output logic             out_valid,
  output ccol_pkg::div_t   out_div,
  output ccol_pkg::carry_t out_carry
);
  import ccol_pkg::*;

  logic signed [N_W-1:0] n1, n2, sv;

  assign sv = N_W'($signed({1'b0, in_root}));
  assign n1 = -N_W'(in_carry.hb) - sv;
  assign n2 = -N_W'(in_carry.hb) + sv;

  // stage 6
  logic             v6;
  logic [N_W-1:0]   an1, an2;
  logic             sn1, sn2, sdx, sdy;
  logic [MAG_W-1:0] adx, ady;
  carry_t           c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an1 <= n1[N_W-1] ? $unsigned(-n1) : $unsigned(n1);
      an2 <= n2[N_W-1] ? $unsigned(-n2) : $unsigned(n2);
      sn1 <= n1[N_W-1];
      sn2 <= n2[N_W-1];
      adx <= in_carry.dx[DELTA_W-1] ? MAG_W'(-in_carry.dx) : in_carry.dx[MAG_W-1:0];
      ady <= in_carry.dy[DELTA_W-1] ? MAG_W'(-in_carry.dy) : in_carry.dy[MAG_W-1:0];
      sdx <= in_carry.dx[DELTA_W-1];
      sdy <= in_carry.dy[DELTA_W-1];
      c6  <= in_carry;
    end
  end

  // stage 7
  logic [MP_W-1:0]  m [DIV_LANES];
  logic [DVD_W-1:0] dvd [DIV_LANES];
  logic             ng [DIV_LANES];

  always_comb begin
    m[LANE_X1]  = adx * an1;
    m[LANE_Y1]  = ady * an1;
    m[LANE_X2]  = adx * an2;
    m[LANE_Y2]  = ady * an2;
    ng[LANE_X1] = sdx ^ sn1;
    ng[LANE_Y1] = sdy ^ sn1;
    ng[LANE_X2] = sdx ^ sn2;
    ng[LANE_Y2] = sdy ^ sn2;
    for (int k = 0; k < DIV_LANES; k++) begin
      dvd[k] = DVD_W'({m[k], 1'b0}) + DVD_W'(c6.a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div.d <= {c6.a, 1'b0};
      for (int k = 0; k < DIV_LANES; k++) begin
        out_div.lane[k].rem  <= dvd[k][DVD_W-1:QUOT_W];
        out_div.lane[k].bits <= dvd[k][QUOT_W-1:0];
        out_div.lane[k].neg  <= ng[k];
      end
      out_carry <= c6;
    end
  end

endmodule

[design/ccol_div_cell.sv]
// ----------------------------------------------------------------------------
// ccol_div_cell
// One restoring divide step on four lanes sharing one divisor.
// ----------------------------------------------------------------------------
module ccol_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  ccol_pkg::div_t   in_div,
  input  ccol_pkg::carry_t in_carry,
  output logic             out_valid,
  output ccol_pkg::div_t   out_div,
  output ccol_pkg::carry_t out_carry
);
  import ccol_pkg::*;

  logic [DREM_W:0] rem_sh [DIV_LANES];
  logic [DREM_W:0] dd;
  logic            ge [DIV_LANES];

  assign dd = {1'b0, in_div.d};

  always_comb begin
    for (int k = 0; k < DIV_LANES; k++) begin
      rem_sh[k] = {in_div.lane[k].rem, in_div.lane[k].bits[QUOT_W-1]};
      ge[k]     = (rem_sh[k] >= dd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_div.d <= in_div.d;
      for (int k = 0; k < DIV_LANES; k++) begin
        out_div.lane[k].rem  <= ge[k] ? DREM_W'(rem_sh[k] - dd) : rem_sh[k][DREM_W-1:0];
        out_div.lane[k].bits <= {in_div.lane[k].bits[QUOT_W-2:0], ge[k]};
        out_div.lane[k].neg  <= in_div.lane[k].neg;
      end
      out_carry <= in_carry;
    end
  end

endmodule

[design/circle_collision_tests.sv]
// ----------------------------------------------------------------------------
// circle_collision_tests
// Tests a configured circle against a rectangle, a segment or a circle.
//
// cfg: register writes (index 0 centre x, 1 centre y, 2 radius), always
//   ready; write only while no item is in flight.
// req: one test item per handshake; func picks the test.
// rsp: one result item per request: hit and contact point (zero on a miss
//   and for the circle test).
// A request passes 5 front stages, 32 root cells (one root bit each), 2 set-up
// stages, 20 divide cells (one quotient bit each) and the output register on
// its way to the result. One item is taken every cycle while req.ready is high.
// The whole pipeline advances together; req.ready is low only while a result
// sits in the output register and rsp.ready is low, and then every stage
// holds. Reset empties the pipeline and clears the configuration to zero.
// ----------------------------------------------------------------------------
module circle_collision_tests (
  input  logic       clk,
  input  logic       rst,
  ccol_cfg_if.sink   cfg,
  ccol_req_if.sink   req,
  ccol_rsp_if.source rsp
);
  import ccol_pkg::*;

  logic en;
  cfg_t cfg_regs;
  req_t req_item;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_CENTER_X: cfg_regs.center_x      <= cfg.data;
        REG_CENTER_Y: cfg_regs.center_y      <= cfg.data;
        REG_RADIUS:   cfg_regs.circle_radius <= cfg.data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    req_item.func         = req.func;
    req_item.rect_x       = req.rect_x;
    req_item.rect_y       = req.rect_y;
    req_item.rect_w       = req.rect_w;
    req_item.rect_h       = req.rect_h;
    req_item.seg_start_x  = req.seg_start_x;
    req_item.seg_start_y  = req.seg_start_y;
    req_item.seg_end_x    = req.seg_end_x;
    req_item.seg_end_y    = req.seg_end_y;
    req_item.other_x      = req.other_x;
    req_item.other_y      = req.other_y;
    req_item.other_radius = req.other_radius;
  end

  logic   sq_v [0:SQRT_STEPS];
  sqrt_t  sq_s [0:SQRT_STEPS];
  carry_t sq_c [0:SQRT_STEPS];
  logic   dv_v [0:DIV_STEPS];
  div_t   dv_s [0:DIV_STEPS];
  carry_t dv_c [0:DIV_STEPS];

  ccol_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .req_item  (req_item),
    .cfg_regs  (cfg_regs),
    .out_valid (sq_v[0]),
    .out_sqrt  (sq_s[0]),
    .out_carry (sq_c[0])
  );

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    ccol_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_v[i]),
      .in_sqrt   (sq_s[i]),
      .in_carry  (sq_c[i]),
      .out_valid (sq_v[i+1]),
      .out_sqrt  (sq_s[i+1]),
      .out_carry (sq_c[i+1])
    );
  end

  ccol_mid u_mid (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v[SQRT_STEPS]),
    .in_root   (sq_s[SQRT_STEPS].root),
    .in_carry  (sq_c[SQRT_STEPS]),
    .out_valid (dv_v[0]),
    .out_div   (dv_s[0]),
    .out_carry (dv_c[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    ccol_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_v[i]),
      .in_div    (dv_s[i]),
      .in_carry  (dv_c[i]),
      .out_valid (dv_v[i+1]),
      .out_div   (dv_s[i+1]),
      .out_carry (dv_c[i+1])
    );
  end

  // candidate points and selection
  carry_t                 cf;
  logic signed [PT_W-1:0] qv [DIV_LANES];
  logic signed [PT_W-1:0] x1, y1, x2, y2;
  logic                   box1, box2, hit_f;
  coord_t                 px_f, py_f;

  assign cf = dv_c[DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_LANES; k++) begin
      qv[k] = $signed({2'b00, dv_s[DIV_STEPS].lane[k].bits});
      if (dv_s[DIV_STEPS].lane[k].neg) begin
        qv[k] = -qv[k];
      end
    end
    x1   = PT_W'(cf.sx) + qv[LANE_X1];
    y1   = PT_W'(cf.sy) + qv[LANE_Y1];
    x2   = PT_W'(cf.sx) + qv[LANE_X2];
    y2   = PT_W'(cf.sy) + qv[LANE_Y2];
    box1 = in_box(x1, cf.sx, cf.ex) && in_box(y1, cf.sy, cf.ey);
    box2 = in_box(x2, cf.sx, cf.ex) && in_box(y2, cf.sy, cf.ey);
    if (cf.seg_ok) begin
      hit_f = box1 || box2;
      if (box1) begin
        px_f = x1[COORD_BITS-1:0];
        py_f = y1[COORD_BITS-1:0];
      end else if (box2) begin
        px_f = x2[COORD_BITS-1:0];
        py_f = y2[COORD_BITS-1:0];
      end else begin
        px_f = '0;
        py_f = '0;
      end
    end else begin
      hit_f = cf.hit_rc;
      px_f  = cf.pt_x;
      py_f  = cf.pt_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.hit     <= hit_f;
      rsp.point_x <= px_f;
      rsp.point_y <= py_f;
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("result valid straight after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.hit) |-> (rsp.point_x == '0 && rsp.point_y == '0))
    else $error("miss with non-zero point");

  a_root_rem: assert property (@(posedge clk) disable iff (rst)
    (sq_v[SQRT_STEPS] && sq_c[SQRT_STEPS].seg_ok) |->
    (sq_s[SQRT_STEPS].rem <= {1'b0, sq_s[SQRT_STEPS].root, 1'b0}))
    else $error("root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_v[DIV_STEPS] && cf.seg_ok) |->
    (dv_s[DIV_STEPS].lane[LANE_X1].rem < dv_s[DIV_STEPS].d &&
     dv_s[DIV_STEPS].lane[LANE_Y1].rem < dv_s[DIV_STEPS].d &&
     dv_s[DIV_STEPS].lane[LANE_X2].rem < dv_s[DIV_STEPS].d &&
     dv_s[DIV_STEPS].lane[LANE_Y2].rem < dv_s[DIV_STEPS].d))
    else $error("divide remainder not below divisor");

endmodule
